/* design/swm_pkg.sv */
// shared constants for the sliding window median filter
// no dependencies; imported by swm_cell and sliding_window_median
package swm_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // window length register
    localparam int                 CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd3;

endpackage

/* design/swm_cell.sv */
// one cell of the sorted window: holds a sample and its age
// takes the post-removal value from its upper neighbor and shifts up on insertion
// depends on swm_pkg
module swm_cell #(
    parameter int SW    = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AW    = 6,
    parameter int LW    = 7,
    parameter int INDEX = 0
) (
    input  logic                 aclk,
    input  logic                 step_en,
    input  logic signed [SW-1:0] x,
    input  logic                 full,
    input  logic [LW-1:0]        vcnt,
    input  logic [LW-1:0]        ucnt,
    input  logic [AW-1:0]        oldest,
    input  logic                 ge_d,
    input  logic [SW-1:0]        v_up,
    input  logic [AW-1:0]        age_up,
    input  logic [SW-1:0]        u_below,
    input  logic [AW-1:0]        uage_below,
    input  logic                 gtu_below,
    output logic [SW-1:0]        u_out,
    output logic [AW-1:0]        uage_out,
    output logic                 gtu_out,
    output logic [SW-1:0]        v_out,
    output logic [AW-1:0]        age_out,
    output logic                 del
);
    import swm_pkg::*;

    logic [SW-1:0] v_reg, v_next;
    logic [AW-1:0] age_reg, age_next;
    logic [SW-1:0] u_here;
    logic [AW-1:0] uage_here;
    logic          gtu_here;

    // value after the oldest sample is taken out
    always_comb begin
        u_here    = ge_d ? v_up : v_reg;
        uage_here = ge_d ? age_up : age_reg;
        gtu_here  = !(LW'(INDEX) < ucnt) || ($signed(u_here) > x);
    end

    always_comb begin
        if (gtu_here) begin
            if (gtu_below) begin
                v_next   = u_below;
                age_next = uage_below + AW'(1);
            end else begin
                v_next   = x;
                age_next = '0;
            end
        end else begin
            v_next   = u_here;
            age_next = uage_here + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            v_reg   <= v_next;
            age_reg <= age_next;
        end
    end

    assign del      = full && (LW'(INDEX) < vcnt) && (age_reg == oldest);
    assign u_out    = u_here;
    assign uage_out = uage_here;
    assign gtu_out  = gtu_here;
    assign v_out    = v_reg;
    assign age_out  = age_reg;

endmodule

/* design/sliding_window_median.sv */
// sliding window median filter, top level
// a row of swm_cell instances keeps the window sorted; depends on swm_pkg
//
// usage:
//   s_ channel: one signed sample per transfer, tuser flags a restart that empties
//   the window before the sample is taken.
//   m_ channel: one median per transfer once the window holds window_length samples;
//   the first window_length-1 samples after a restart give no result.
//   cfg channel: writes window_length (0 acts as 1, above MAX_WINDOW acts as
//   MAX_WINDOW) and empties the window; write only while the block is idle.
// timing:
//   one sample per cycle while s_tready stays high; every cell removes the oldest sample
//   and inserts the new one in the same register update, so the cell row sets the rate.
//   a median is registered first in the cell row, then in the output register behind
//   the median select, before it shows on m_tvalid.
// reset and stall:
//   reset empties the window and sets window_length to 3.
//   while the receiver stalls, one finished median waits in the output register and
//   one more in the cell row; s_tready drops only when both are held.
module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // restart
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // median
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import swm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int XW = CFG_WIDTH + LW;

    logic [CFG_WIDTH-1:0] len_cfg_reg;
    logic [LW-1:0]        fill_reg, fill_next;
    logic                 pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SW-1:0]        m_data_reg;

    logic [LW-1:0]        eff_len;
    logic [LW-1:0]        vcnt, ucnt, vcnt_inc;
    logic                 full;
    logic                 s_xfer, m_move, res;
    logic signed [SW-1:0] x;

    logic [SW-1:0] v_w    [MAX_WINDOW];
    logic [AW-1:0] age_w  [MAX_WINDOW];
    logic [SW-1:0] u_w    [MAX_WINDOW];
    logic [AW-1:0] uage_w [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] gtu_w;
    logic [MAX_WINDOW-1:0] del_vec;
    logic [MAX_WINDOW-1:0] ge_d;

    always_comb begin
        if (len_cfg_reg == '0) begin
            eff_len = LW'(1);
        end else if (XW'(len_cfg_reg) > XW'(MAX_WINDOW)) begin
            eff_len = LW'(MAX_WINDOW);
        end else begin
            eff_len = LW'(len_cfg_reg);
        end
    end

    assign x        = s_tdata[SW-1:0];
    assign vcnt     = s_tuser ? '0 : fill_reg;
    assign full     = (vcnt == eff_len);
    assign ucnt     = full ? vcnt - LW'(1) : vcnt;
    assign vcnt_inc = full ? vcnt : vcnt + LW'(1);
    assign res      = (vcnt_inc == eff_len);

    assign m_move    = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !(pend_reg && m_valid_reg && !m_tready);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
            assign ge_d[k] = |del_vec[k:0];
            swm_cell #(
                .SW    (SW),
                .AW    (AW),
                .LW    (LW),
                .INDEX (k)
            ) u_cell (
                .aclk       (aclk),
                .step_en    (s_xfer),
                .x          (x),
                .full       (full),
                .vcnt       (vcnt),
                .ucnt       (ucnt),
                .oldest     (AW'(eff_len - LW'(1))),
                .ge_d       (ge_d[k]),
                .v_up       ((k == MAX_WINDOW - 1) ? '0 : v_w[(k + 1) % MAX_WINDOW]),
                .age_up     ((k == MAX_WINDOW - 1) ? '0 : age_w[(k + 1) % MAX_WINDOW]),
                .u_below    ((k == 0) ? '0 : u_w[(k + MAX_WINDOW - 1) % MAX_WINDOW]),
                .uage_below ((k == 0) ? '0 : uage_w[(k + MAX_WINDOW - 1) % MAX_WINDOW]),
                .gtu_below  ((k == 0) ? 1'b0 : gtu_w[(k + MAX_WINDOW - 1) % MAX_WINDOW]),
                .u_out      (u_w[k]),
                .uage_out   (uage_w[k]),
                .gtu_out    (gtu_w[k]),
                .v_out      (v_w[k]),
                .age_out    (age_w[k]),
                .del        (del_vec[k])
            );
        end
    endgenerate

    always_comb begin
        fill_next    = fill_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (m_move) begin
            m_valid_next = 1'b1;
            pend_next    = 1'b0;
        end
        if (s_xfer) begin
            fill_next = vcnt_inc;
            if (res) begin
                pend_next = 1'b1;
            end
        end
        if (cfg_valid) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= CFG_RESET;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                len_cfg_reg <= cfg_data;
            end
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // median select from the cell row
    always_ff @(posedge aclk) begin
        if (m_move) begin
            m_data_reg <= v_w[AW'(eff_len >> 1)];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'(m_data_reg);

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_len)
        else $error("fill count above window length");

    a_one_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(del_vec))
        else $error("more than one cell marked oldest");

    a_full_removes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && full |-> $onehot(del_vec))
        else $error("full window without exactly one oldest cell");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && m_valid_reg && !m_tready |=> pend_reg && m_valid_reg)
        else $error("held median lost under stall");
`endif

endmodule

/* tb/sliding_window_median_test.sv */
// self-checking testbench for the sliding window median filter: directed and random
// samples, window length changes between phases, random idling and a long output stall
// depends on swm_pkg and sliding_window_median
`timescale 1ns / 100ps

module sliding_window_median_test;

    localparam int SW   = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAXW = swm_pkg::MAX_WINDOW_DEF;
    localparam int CW   = swm_pkg::CFG_WIDTH;
    localparam int DW   = ((SW + 7) / 8) * 8;

    typedef enum logic {FEED_SAMPLE, FEED_LENGTH} feed_kind_t;

    typedef struct {
        feed_kind_t      kind;
        logic [SW-1:0]   sample;
        logic            restart;
        logic [CW-1:0]   length;
    } feed_item_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // sample
    logic [DW-1:0]  s_tdata = '0;
    // restart
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // median
    logic [DW-1:0]  m_tdata;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [CW-1:0]  cfg_data = '0;

    feed_item_t             pending_feed[$];
    logic signed [SW-1:0]   medians_due[$];
    logic signed [SW-1:0]   win_ring[MAXW];
    logic [CW-1:0]          length_reg;
    int                     win_fill;
    int                     win_wp;
    int                     results_owed = 0;
    int                     mismatches = 0;
    logic                   feed_done = 1'b0;
    logic                   calm_tail = 1'b0;

    sliding_window_median dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic push_sample(input logic [SW-1:0] v, input logic r);
        feed_item_t it;
        it.kind = FEED_SAMPLE;
        it.sample = v;
        it.restart = r;
        it.length = '0;
        pending_feed.push_back(it);
    endtask

    task automatic push_length(input logic [CW-1:0] n);
        feed_item_t it;
        it.kind = FEED_LENGTH;
        it.sample = '0;
        it.restart = 1'b0;
        it.length = n;
        pending_feed.push_back(it);
    endtask

    // rank floor(len/2) of the newest len samples in the ring
    function automatic logic signed [SW-1:0] ring_median(input int len);
        logic signed [SW-1:0] ordered[MAXW];
        logic signed [SW-1:0] v;
        int j;
        for (int i = 0; i < len; i++) begin
            v = win_ring[(win_wp + MAXW - 1 - i) % MAXW];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        return ordered[len/2];
    endfunction

    // sender
    always @(posedge aclk) begin : drive
        feed_item_t it;
        logic nv_s;
        logic nv_cfg;
        int gap;
        int settle;
        int samples_sent;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            feed_done <= 1'b0;
            calm_tail <= 1'b0;
            gap = 0;
            settle = 0;
            samples_sent = 0;
        end else begin
            nv_s = s_tvalid && !s_tready;
            nv_cfg = cfg_valid && !cfg_ready;
            if (s_tvalid && s_tready) begin
                samples_sent++;
                if ((samples_sent % 128) >= 40 && pending_feed.size() >= 150
                        && $urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 9);
            end
            if (!s_tvalid && !cfg_valid && results_owed == 0)
                settle++;
            else
                settle = 0;
            if (!nv_s && !nv_cfg) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_feed.size() > 0) begin
                    if (pending_feed[0].kind == FEED_LENGTH) begin
                        // change length only once the block has drained
                        if (settle >= 8) begin
                            it = pending_feed.pop_front();
                            nv_cfg = 1'b1;
                            cfg_data <= it.length;
                        end
                    end else begin
                        it = pending_feed.pop_front();
                        nv_s = 1'b1;
                        s_tdata <= DW'(it.sample);
                        s_tuser <= it.restart;
                    end
                end
            end
            s_tvalid <= nv_s;
            cfg_valid <= nv_cfg;
            feed_done <= (pending_feed.size() == 0) && !nv_s && !nv_cfg;
            calm_tail <= pending_feed.size() < 150;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge aclk) begin : receive
        int stall_left;
        int medians_taken;
        logic hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            medians_taken = 0;
            hold_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                medians_taken++;
            if (!hold_done && medians_taken >= 150) begin
                stall_left = 60;
                hold_done = 1'b1;
            end else if (stall_left == 0 && !calm_tail && (medians_taken % 100) >= 30
                    && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // prediction and checking
    always @(posedge aclk) begin : observe
        logic signed [SW-1:0] want;
        int eff;
        if (!aresetn) begin
            length_reg = swm_pkg::CFG_RESET;
            win_fill = 0;
            win_wp = 0;
            medians_due.delete();
            results_owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                length_reg = cfg_data;
                win_fill = 0;
                win_wp = 0;
            end
            if (s_tvalid && s_tready) begin
                eff = (length_reg == 0) ? 1 : (length_reg > MAXW) ? MAXW : int'(length_reg);
                if (s_tuser) begin
                    win_fill = 0;
                    win_wp = 0;
                end
                win_ring[win_wp] = s_tdata[SW-1:0];
                win_wp = (win_wp + 1) % MAXW;
                if (win_fill < eff)
                    win_fill++;
                if (win_fill == eff)
                    medians_due.push_back(ring_median(eff));
            end
            if (m_tvalid && m_tready) begin
                if (medians_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected median transfer: %0d", $signed(m_tdata[SW-1:0]));
                end else begin
                    want = medians_due.pop_front();
                    if (m_tdata[SW-1:0] !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("median mismatch: expected %0d, got %0d",
                                     want, $signed(m_tdata[SW-1:0]));
                    end
                end
            end
            results_owed <= medians_due.size();
        end
    end

    initial begin : stimulus
        int random_sent;
        int phase;
        int eff;
        int count;
        logic [CW-1:0] len;
        logic [SW-1:0] v;

        // reset length of 3, extremes and ties
        push_sample({1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(SW'(1), 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_sample({1'b0, {(SW-1){1'b1}}}, 1'b0);
        // restart mid window
        push_sample(SW'(7), 1'b1);
        push_sample(-SW'(7), 1'b0);
        push_sample(SW'(3), 1'b0);
        // zero length acts as one
        push_length('0);
        push_sample({1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_sample('1, 1'b1);
        // even length takes the upper middle
        push_length(CW'(2));
        push_sample(SW'(5), 1'b0);
        push_sample(-SW'(5), 1'b0);
        push_sample(SW'(5), 1'b0);
        push_sample(SW'(5), 1'b0);
        push_sample({1'b1, {(SW-1){1'b0}}}, 1'b0);

        random_sent = 0;
        phase = 0;
        while (random_sent < 1100) begin
            case (phase)
                0: len = '1;
                1: len = '0;
                2: len = CW'(MAXW);
                3: len = CW'(1);
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1: len = CW'($urandom_range(10, MAXW - 1));
                        2: len = CW'($urandom_range(0, 1) ? MAXW : $urandom_range(MAXW, 127));
                        default: len = CW'($urandom_range(1, 9));
                    endcase
                end
            endcase
            push_length(len);
            eff = (len == 0) ? 1 : (len > MAXW) ? MAXW : int'(len);
            count = eff + $urandom_range(16, 64);
            for (int k = 0; k < count; k++) begin
                case ($urandom_range(0, 5))
                    3: v = $urandom_range(0, 8) - 4;
                    4: begin
                        case ($urandom_range(0, 3))
                            0: v = {1'b0, {(SW-1){1'b1}}};
                            1: v = {1'b1, {(SW-1){1'b0}}};
                            2: v = '0;
                            default: v = '1;
                        endcase
                    end
                    default: v = $urandom;
                endcase
                push_sample(v, $urandom_range(0, 47) == 0);
            end
            random_sent += count;
            phase++;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (!feed_done)
            @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS sliding_window_median");
        else
            $display("FAIL sliding_window_median");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("FAIL sliding_window_median");
        $finish;
    end

endmodule
